// ===== rtl/gregorian_date_difference_defines.svh =====
// Assertion macros for the date difference block
`ifndef GREGORIAN_DATE_DIFFERENCE_DEFINES_SVH
`define GREGORIAN_DATE_DIFFERENCE_DEFINES_SVH

// same-cycle implication, off during reset
`define GDD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gdd check failed");

// next-cycle implication, off during reset
`define GDD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("gdd check failed");

`endif

// ===== rtl/gdd_pkg.sv =====
// Types, constants, microcode and month tables for the date difference block
package gdd_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int COUNT_W = 22;
    localparam int ACC_W   = 24;
    localparam int PC_W    = 5;
    localparam int Q_W     = 8;
    localparam int DIV_SHIFT = 19;
    localparam int PROD_W    = 27;

    localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
    localparam logic [12:0]        DIV100_MUL = 13'd5243;
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
    localparam logic [8:0]         DAYS_YEAR  = 9'd365;

    localparam logic [3:0] OP_DIV_Y   = 4'd0;
    localparam logic [3:0] OP_LEAP    = 4'd1;
    localparam logic [3:0] OP_CHECK   = 4'd2;
    localparam logic [3:0] OP_JMP_BAD = 4'd3;
    localparam logic [3:0] OP_DIV_P   = 4'd4;
    localparam logic [3:0] OP_ACC_Q   = 4'd5;
    localparam logic [3:0] OP_ACC_P   = 4'd6;
    localparam logic [3:0] OP_ACC_MD  = 4'd7;
    localparam logic [3:0] OP_ABS     = 4'd8;
    localparam logic [3:0] OP_DONE    = 4'd9;

    localparam logic [PC_W-1:0] PC_DONE = 5'd16;

    typedef struct packed {
        logic [YEAR_W-1:0]  first_year;
        logic [MONTH_W-1:0] first_month;
        logic [DAY_W-1:0]   first_day;
        logic [YEAR_W-1:0]  second_year;
        logic [MONTH_W-1:0] second_month;
        logic [DAY_W-1:0]   second_day;
    } t_in_word;

    typedef struct packed {
        logic [COUNT_W-1:0] day_count;
        logic               date_invalid;
    } t_out_word;

    typedef struct packed {
        logic [3:0]      op;
        logic            sel;
        logic [PC_W-1:0] target;
    } t_uword;

    function automatic t_uword gdd_ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '{op: OP_DONE, sel: 1'b0, target: '0};
        case (pc)
            5'd0:  w = '{op: OP_DIV_Y,   sel: 1'b0, target: '0};
            5'd1:  w = '{op: OP_LEAP,    sel: 1'b0, target: '0};
            5'd2:  w = '{op: OP_CHECK,   sel: 1'b0, target: '0};
            5'd3:  w = '{op: OP_DIV_Y,   sel: 1'b1, target: '0};
            5'd4:  w = '{op: OP_LEAP,    sel: 1'b1, target: '0};
            5'd5:  w = '{op: OP_CHECK,   sel: 1'b1, target: '0};
            5'd6:  w = '{op: OP_JMP_BAD, sel: 1'b0, target: PC_DONE};
            5'd7:  w = '{op: OP_DIV_P,   sel: 1'b0, target: '0};
            5'd8:  w = '{op: OP_ACC_Q,   sel: 1'b0, target: '0};
            5'd9:  w = '{op: OP_ACC_P,   sel: 1'b0, target: '0};
            5'd10: w = '{op: OP_ACC_MD,  sel: 1'b0, target: '0};
            5'd11: w = '{op: OP_DIV_P,   sel: 1'b1, target: '0};
            5'd12: w = '{op: OP_ACC_Q,   sel: 1'b1, target: '0};
            5'd13: w = '{op: OP_ACC_P,   sel: 1'b1, target: '0};
            5'd14: w = '{op: OP_ACC_MD,  sel: 1'b1, target: '0};
            5'd15: w = '{op: OP_ABS,     sel: 1'b0, target: '0};
            5'd16: w = '{op: OP_DONE,    sel: 1'b0, target: '0};
            default: w = '{op: OP_DONE,  sel: 1'b0, target: '0};
        endcase
        return w;
    endfunction

    function automatic logic [DAY_W-1:0] gdd_month_days(input logic [MONTH_W-1:0] m,
                                                        input logic leap);
        logic [DAY_W-1:0] n;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   n = 5'd30;
            4'd2:    n = leap ? 5'd29 : 5'd28;
            default: n = 5'd0;
        endcase
        return n;
    endfunction

    function automatic logic [8:0] gdd_month_start(input logic [MONTH_W-1:0] m);
        logic [8:0] n;
        case (m)
            4'd1:    n = 9'd0;
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

endpackage

// ===== rtl/gdd_if.sv =====
// Valid/ready channel interfaces for date pairs and day counts
interface gdd_in_if;
    logic                valid;
    logic                ready;
    gdd_pkg::t_in_word   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gdd_out_if;
    logic                valid;
    logic                ready;
    gdd_pkg::t_out_word  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/gregorian_date_difference.sv =====
// Day count between two Gregorian dates, run by a microcoded sequencer
//
//  channel  dir  word                                   accepted when
//  i_in     in   two dates: year, month, day each       valid & ready
//  o_out    out  day_count, date_invalid                valid & ready
//
//  An item runs through the 17-step microcode program in gdd_ucode after
//  acceptance, one step per cycle; a malformed date jumps to the last step.
//  One item is in work at a time; the next is taken once the result has
//  moved to the output register, which may still wait on o_out.ready.
//  The last step holds while the output register is full.
//  Reset is synchronous, active low, and clears the sequencer and valid.
module gregorian_date_difference (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gdd_in_if.sink        i_in,
    gdd_out_if.source     o_out
);
    import gdd_pkg::*;

    logic                r_busy;
    logic [PC_W-1:0]     r_pc;
    logic                r_out_valid;
    t_out_word           r_out;

    logic [YEAR_W-1:0]   r_y0, r_y1;
    logic [MONTH_W-1:0]  r_m0, r_m1;
    logic [DAY_W-1:0]    r_d0, r_d1;
    logic                r_leap0, r_leap1;
    logic                r_bad;
    logic [Q_W-1:0]      r_q;
    logic [ACC_W-1:0]    r_acc;

    t_uword              uw;
    logic [YEAR_W-1:0]   y, p, dv, hund;
    logic [MONTH_W-1:0]  m;
    logic [DAY_W-1:0]    d;
    logic                leap_s, leap_new, date_ok, accept, done_go;
    logic [PROD_W-1:0]   prod;
    logic [Q_W-1:0]      q;
    logic [ACC_W-1:0]    term, n_acc;
    logic [PC_W-1:0]     n_pc;

    assign accept      = i_in.valid && i_in.ready;
    assign i_in.ready  = !r_busy;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_comb begin
        uw     = gdd_ucode(r_pc);
        y      = uw.sel ? r_y1 : r_y0;
        m      = uw.sel ? r_m1 : r_m0;
        d      = uw.sel ? r_d1 : r_d0;
        leap_s = uw.sel ? r_leap1 : r_leap0;
        p      = y - 14'd1;
        dv     = (uw.op == OP_DIV_P) ? p : y;
        prod   = PROD_W'(dv) * PROD_W'(DIV100_MUL);
        q      = prod[DIV_SHIFT +: Q_W];
        hund   = YEAR_W'({6'd0, r_q} * 14'd100);
        leap_new = (y[1:0] == 2'd0) && ((y != hund) || (r_q[1:0] == 2'd0));
        date_ok  = (y != '0) && (y <= YEAR_MAX) && (m != '0) && (m <= MONTH_DEC)
                   && (d != '0) && (d <= gdd_month_days(m, leap_s));
        case (uw.op)
            OP_ACC_Q:  term = ACC_W'(r_q >> 2) - ACC_W'(r_q);
            OP_ACC_P:  term = ACC_W'(p) * ACC_W'(DAYS_YEAR) + ACC_W'(p >> 2);
            OP_ACC_MD: term = ACC_W'(gdd_month_start(m))
                              + ACC_W'(leap_s && (m > MONTH_FEB)) + ACC_W'(d);
            default:   term = '0;
        endcase
        n_acc   = uw.sel ? (r_acc - term) : (r_acc + term);
        done_go = (uw.op == OP_DONE) && (!r_out_valid || o_out.ready);
        if ((uw.op == OP_JMP_BAD) && r_bad) begin
            n_pc = uw.target;
        end else begin
            n_pc = r_pc + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
                r_pc   <= '0;
            end else if (r_busy) begin
                if (uw.op == OP_DONE) begin
                    if (done_go) begin
                        r_busy <= 1'b0;
                    end
                end else begin
                    r_pc <= n_pc;
                end
            end
            if (r_busy && done_go) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_y0  <= i_in.data.first_year;
            r_m0  <= i_in.data.first_month;
            r_d0  <= i_in.data.first_day;
            r_y1  <= i_in.data.second_year;
            r_m1  <= i_in.data.second_month;
            r_d1  <= i_in.data.second_day;
            r_acc <= '0;
            r_bad <= 1'b0;
        end else if (r_busy) begin
            case (uw.op)
                OP_DIV_Y, OP_DIV_P: r_q <= q;
                OP_LEAP: begin
                    if (uw.sel) begin
                        r_leap1 <= leap_new;
                    end else begin
                        r_leap0 <= leap_new;
                    end
                end
                OP_CHECK: r_bad <= r_bad || !date_ok;
                OP_ACC_Q, OP_ACC_P, OP_ACC_MD: r_acc <= n_acc;
                OP_ABS: begin
                    if (r_acc[ACC_W-1]) begin
                        r_acc <= -r_acc;
                    end
                end
                OP_DONE: begin
                    if (done_go) begin
                        r_out.day_count    <= r_bad ? '0 : r_acc[COUNT_W-1:0];
                        r_out.date_invalid <= r_bad;
                    end
                end
                default: r_acc <= r_acc;
            endcase
        end
    end

endmodule

// ===== rtl/gdd_checker.sv =====
// Port-level checks for the date difference block, bound to the top level
`include "gregorian_date_difference_defines.svh"

module gdd_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [gdd_pkg::COUNT_W-1:0] i_day_count,
    input  logic                        i_date_invalid
);
    import gdd_pkg::*;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 22'd3652058;

    logic stall;

    assign stall = i_out_valid && !i_out_ready;

    `GDD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, stall, i_out_valid)
    `GDD_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, stall, $stable({i_day_count, i_date_invalid}))
    `GDD_ASSERT_NOW(a_invalid_zero, i_clk, i_rst_n, i_out_valid && i_date_invalid, i_day_count == '0)
    `GDD_ASSERT_NOW(a_count_range, i_clk, i_rst_n, i_out_valid, i_day_count <= COUNT_MAX)

endmodule

bind gregorian_date_difference gdd_checker u_gdd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_day_count    (o_out.data.day_count),
    .i_date_invalid (o_out.data.date_invalid)
);
